### hw/rtl/mdcf_pkg.sv
// mdcf_pkg: shared constants, types and helpers of the modulated damped comb filter
// used by every interface and module under hw/rtl but mdcf_ram; depends on nothing
package mdcf_pkg;

    localparam int LINE_DEPTH  = 8192;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd3;

    localparam logic [16:0] BASE_DELAY_RESET  = 17'd10000;
    localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;

    localparam logic signed [15:0] GAIN_MAX_S      = 16'sd32440;
    localparam logic [14:0]        DAMP_MAX        = 15'd32440;
    localparam logic signed [15:0] SIX_TENTHS_Q15  = 16'sd19661;
    localparam logic signed [13:0] TWO_TENTHS_Q15  = 14'sd6554;
    localparam logic signed [31:0] FACTOR_ONE      = 32'sd1073741824;
    localparam int                 FACTOR_SHIFT    = 30;
    localparam logic [16:0]        US_MIN          = 17'd200;
    localparam logic [16:0]        US_MAX          = 17'd80000;

    // floor(q / 15625) as (q * RECIP_15625) >> RECIP_SHIFT, exact for q below 2^29
    localparam int          RECIP_SHIFT = 44;
    localparam logic [30:0] RECIP_15625 = 31'd1125899907;
    localparam int          QUOT_W      = 16;

    typedef logic signed [15:0] in_sample_t;
    typedef logic signed [23:0] line_sample_t;

    typedef struct packed {
        logic [16:0]        base_delay_us;
        logic signed [15:0] feedback_gain;
        logic [14:0]        damping_gain;
        logic [17:0]        sample_rate_hz;
    } mdcf_cfg_t;

    typedef struct packed {
        in_sample_t         x;
        logic [ADDR_W-1:0]  tap;
        logic signed [15:0] fbk;
        logic [14:0]        damp;
    } mdcf_job_t;

    function automatic line_sample_t sat24(input logic signed [26:0] v);
        line_sample_t r;
        if (v > 27'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -27'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/mdcf_if.sv
// mdcf_if: valid/ready channel interfaces of the comb filter (input, result, config)
// depends on mdcf_pkg for payload types
interface mdcf_in_if import mdcf_pkg::*; ();
    logic       valid;
    logic       ready;
    in_sample_t in_sample;
    in_sample_t mod_sample;
    modport source (output valid, output in_sample, output mod_sample, input ready);
    modport sink (input valid, input in_sample, input mod_sample, output ready);
endinterface

interface mdcf_out_if import mdcf_pkg::*; ();
    logic         valid;
    logic         ready;
    line_sample_t out_sample;
    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

interface mdcf_cfg_if import mdcf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/modulated_damped_comb_filter.sv
// modulated_damped_comb_filter: top level with config registers, front, queue and back
// depends on mdcf_pkg, mdcf_if, mdcf_front, mdcf_queue, mdcf_back (and mdcf_ram)
//
// channel  dir  payload                      accepted when
// audio    in   in_sample, mod_sample        audio.valid && audio.ready
// result   out  out_sample                   result.valid && result.ready
// cfg      in   index, data                  cfg.valid && cfg.ready (always ready)
//
// back end steps each word through its read, damp multiply, lowpass add and feedback
// multiply before the write-back; the write-back overlaps the next word's delay line read
// front end is a 4-stage pipeline, a 2-entry queue sits between front and back
// no clearing pass after reset: a fill flag makes unwritten entries read as zero
// result register lets the back end start the next word while a result waits
module modulated_damped_comb_filter import mdcf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    mdcf_in_if.sink    audio,
    mdcf_out_if.source result,
    mdcf_cfg_if.sink   cfg
);

    logic [16:0]        base_delay_us_reg;
    logic signed [15:0] feedback_gain_reg;
    logic [14:0]        damping_gain_reg;
    logic [17:0]        sample_rate_hz_reg;
    mdcf_cfg_t          cfg_regs;

    logic      fq_valid, fq_ready;
    mdcf_job_t fq_job;
    logic      qb_valid, qb_ready;
    mdcf_job_t qb_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_us_reg  <= BASE_DELAY_RESET;
            feedback_gain_reg  <= '0;
            damping_gain_reg   <= '0;
            sample_rate_hz_reg <= SAMPLE_RATE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BASE_DELAY:  base_delay_us_reg  <= cfg.data[16:0];
                CFG_FEEDBACK:    feedback_gain_reg  <= cfg.data[15:0];
                CFG_DAMPING:     damping_gain_reg   <= cfg.data[14:0];
                CFG_SAMPLE_RATE: sample_rate_hz_reg <= cfg.data[17:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_regs.base_delay_us  = base_delay_us_reg;
    assign cfg_regs.feedback_gain  = feedback_gain_reg;
    assign cfg_regs.damping_gain   = damping_gain_reg;
    assign cfg_regs.sample_rate_hz = sample_rate_hz_reg;

    mdcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio),
        .cfg       (cfg_regs),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    mdcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    mdcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .result    (result)
    );

endmodule

### hw/rtl/mdcf_ram.sv
// mdcf_ram: generic one-write one-read ram with registered read data
// no dependencies
module mdcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/mdcf_front.sv
// mdcf_front: accepts words, works out tap, feedback and damping for each one
// depends on mdcf_pkg and mdcf_in_if
module mdcf_front import mdcf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    mdcf_in_if.sink    audio,
    input  mdcf_cfg_t  cfg,
    output logic       job_valid,
    input  logic       job_ready,
    output mdcf_job_t  job
);

    typedef struct packed {
        in_sample_t         x;
        logic signed [15:0] fbk;
        logic [14:0]        damp;
    } carry_t;

    logic adv;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    carry_t c1_reg, c2_reg, c3_reg, c4_reg;
    logic [16:0]        base_reg;
    logic [30:0]        factor_reg;
    logic [17:0]        dyn_raw_reg;
    logic [28:0]        quot_in_reg;
    logic [QUOT_W-1:0]  quot_reg;

    logic signed [30:0] six_prod;
    logic signed [29:0] two_prod;
    logic signed [31:0] factor_sum;
    logic signed [14:0] offset;
    logic signed [15:0] fb_c;
    logic signed [16:0] fb_sum;
    logic signed [15:0] fbk;
    logic [14:0]        d_c;
    logic signed [16:0] d_sum;
    logic [14:0]        damp;
    logic [16:0]        base_c;
    logic [47:0]        bf_prod;
    logic [16:0]        dyn_c;
    logic [17:0]        rate_eff;
    logic [34:0]        rate_prod;
    logic [59:0]        q_prod;
    logic [ADDR_W-1:0]  tap;

    assign adv = !s4_valid_reg || job_ready;
    assign audio.ready = adv;

    // stage 1: modulation products, gain clamps and base delay clamp
    always_comb
    begin
        six_prod   = SIX_TENTHS_Q15 * audio.mod_sample;
        two_prod   = TWO_TENTHS_Q15 * audio.mod_sample;
        factor_sum = FACTOR_ONE + {six_prod[30], six_prod};
        offset     = two_prod[29:15];

        if (cfg.feedback_gain > GAIN_MAX_S)
        begin
            fb_c = GAIN_MAX_S;
        end
        else if (cfg.feedback_gain < -GAIN_MAX_S)
        begin
            fb_c = -GAIN_MAX_S;
        end
        else
        begin
            fb_c = cfg.feedback_gain;
        end
        fb_sum = {fb_c[15], fb_c} + {{2{offset[14]}}, offset};
        if (fb_sum > 17'sd32440)
        begin
            fbk = GAIN_MAX_S;
        end
        else if (fb_sum < -17'sd32440)
        begin
            fbk = -GAIN_MAX_S;
        end
        else
        begin
            fbk = fb_sum[15:0];
        end

        d_c   = (cfg.damping_gain > DAMP_MAX) ? DAMP_MAX : cfg.damping_gain;
        d_sum = {2'b00, d_c} + {{2{offset[14]}}, offset};
        if (d_sum[16])
        begin
            damp = '0;
        end
        else if (d_sum > 17'sd32440)
        begin
            damp = DAMP_MAX;
        end
        else
        begin
            damp = d_sum[14:0];
        end

        if (cfg.base_delay_us < US_MIN)
        begin
            base_c = US_MIN;
        end
        else if (cfg.base_delay_us > US_MAX)
        begin
            base_c = US_MAX;
        end
        else
        begin
            base_c = cfg.base_delay_us;
        end
    end

    // stage 2: modulated delay in us
    assign bf_prod = base_reg * factor_reg;

    // stage 3: delay clamp and conversion to samples
    always_comb
    begin
        if (dyn_raw_reg < {1'b0, US_MIN})
        begin
            dyn_c = US_MIN;
        end
        else if (dyn_raw_reg > {1'b0, US_MAX})
        begin
            dyn_c = US_MAX;
        end
        else
        begin
            dyn_c = dyn_raw_reg[16:0];
        end
        rate_eff  = (cfg.sample_rate_hz == '0) ? 18'd1 : cfg.sample_rate_hz;
        rate_prod = dyn_c * rate_eff;
    end

    // stage 4: divide by one million (shift by 6, then reciprocal of 15625)
    assign q_prod = quot_in_reg * RECIP_15625;

    always_comb
    begin
        if (quot_reg == '0)
        begin
            tap = ADDR_W'(1);
        end
        else if ({1'b0, quot_reg} > (QUOT_W + 1)'(LINE_DEPTH - 1))
        begin
            tap = ADDR_W'(LINE_DEPTH - 1);
        end
        else
        begin
            tap = quot_reg[ADDR_W-1:0];
        end
    end

    assign job_valid = s4_valid_reg;
    assign job.x     = c4_reg.x;
    assign job.tap   = tap;
    assign job.fbk   = c4_reg.fbk;
    assign job.damp  = c4_reg.damp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= audio.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg.x    <= audio.in_sample;
            c1_reg.fbk  <= fbk;
            c1_reg.damp <= damp;
            base_reg    <= base_c;
            factor_reg  <= factor_sum[30:0];

            c2_reg      <= c1_reg;
            dyn_raw_reg <= bf_prod[FACTOR_SHIFT+17:FACTOR_SHIFT];

            c3_reg      <= c2_reg;
            quot_in_reg <= rate_prod[34:6];

            c4_reg      <= c3_reg;
            quot_reg    <= q_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        end
    end

endmodule

### hw/rtl/mdcf_queue.sv
// mdcf_queue: short fifo of prepared jobs between front and back
// depends on mdcf_pkg
module mdcf_queue import mdcf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  mdcf_job_t push_job,
    output logic      pop_valid,
    input  logic      pop_ready,
    output mdcf_job_t pop_job
);

    mdcf_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  head_reg, head_next;
    logic [QPTR_W-1:0]  tail_reg, tail_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/mdcf_back.sv
// mdcf_back: delay line access, lowpass update, feedback write and result register
// depends on mdcf_pkg, mdcf_out_if and mdcf_ram
module mdcf_back import mdcf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  mdcf_job_t job,
    mdcf_out_if.source result
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DAMP    = 3'd1;
    localparam logic [2:0] ST_LOWPASS = 3'd2;
    localparam logic [2:0] ST_FEED    = 3'd3;
    localparam logic [2:0] ST_WRITE   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   wp_reg;
    logic                full_reg;
    line_sample_t        lp_reg;
    logic                out_valid_reg;
    line_sample_t        out_data_reg;

    in_sample_t          x_reg;
    logic signed [15:0]  fbk_reg;
    logic [14:0]         damp_reg;
    logic                hit_reg;
    logic                byp_reg;
    line_sample_t        byp_data_reg;
    line_sample_t        delayed_reg;
    logic signed [25:0]  p1_reg;
    logic signed [24:0]  p2_reg;

    logic [ADDR_W-1:0]   wp_inc;
    logic                full_inc;
    logic                wr_ok;
    logic                pop;
    logic [ADDR_W-1:0]   issue_wp;
    logic                issue_full;
    logic [ADDR_W-1:0]   rd_diff;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_hit;
    logic                rd_byp;
    logic [23:0]         rdata;
    line_sample_t        delayed;
    logic signed [24:0]  diff;
    logic signed [40:0]  prod1;
    logic signed [39:0]  prod2;
    logic signed [26:0]  lp_sum;
    logic signed [26:0]  w_sum;
    line_sample_t        wval;

    assign wp_inc   = (wp_reg == ADDR_W'(LINE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign full_inc = full_reg || (wp_reg == ADDR_W'(LINE_DEPTH - 1));
    assign wr_ok    = (state_reg == ST_WRITE) && (!out_valid_reg || result.ready);

    // next job may start in the cycle the current one writes back
    assign job_ready  = (state_reg == ST_IDLE) || wr_ok;
    assign pop        = job_valid && job_ready;
    assign issue_wp   = (state_reg == ST_WRITE) ? wp_inc : wp_reg;
    assign issue_full = (state_reg == ST_WRITE) ? full_inc : full_reg;
    assign rd_diff    = issue_wp - job.tap;
    assign rd_addr    = (issue_wp >= job.tap) ? rd_diff : rd_diff + ADDR_W'(LINE_DEPTH);
    // entries never written since reset read as zero
    assign rd_hit     = issue_full || (rd_addr < issue_wp);
    assign rd_byp     = (state_reg == ST_WRITE) && (rd_addr == wp_reg);

    mdcf_ram #(
        .WIDTH (24),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (wp_reg),
        .wdata (wval),
        .re    (pop),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (byp_reg)
        begin
            delayed = byp_data_reg;
        end
        else if (hit_reg)
        begin
            delayed = rdata;
        end
        else
        begin
            delayed = '0;
        end
        diff   = {delayed[23], delayed} - {lp_reg[23], lp_reg};
        prod1  = $signed({1'b0, damp_reg}) * diff;
        lp_sum = {{3{lp_reg[23]}}, lp_reg} + {p1_reg[25], p1_reg};
        prod2  = lp_reg * fbk_reg;
        w_sum  = {{11{x_reg[15]}}, x_reg} + {{2{p2_reg[24]}}, p2_reg};
        wval   = sat24(w_sum);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_DAMP;
                end
            end
            ST_DAMP:
            begin
                state_next = ST_LOWPASS;
            end
            ST_LOWPASS:
            begin
                state_next = ST_FEED;
            end
            ST_FEED:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (wr_ok)
                begin
                    state_next = pop ? ST_DAMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOWPASS)
            begin
                lp_reg <= sat24(lp_sum);
            end
            if (wr_ok)
            begin
                wp_reg        <= wp_inc;
                full_reg      <= full_inc;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg        <= job.x;
            fbk_reg      <= job.fbk;
            damp_reg     <= job.damp;
            hit_reg      <= rd_hit;
            byp_reg      <= rd_byp;
            byp_data_reg <= wval;
        end
        if (state_reg == ST_DAMP)
        begin
            delayed_reg <= delayed;
            p1_reg      <= prod1[40:15];
        end
        if (state_reg == ST_FEED)
        begin
            p2_reg <= prod2[39:15];
        end
        if (wr_ok)
        begin
            out_data_reg <= delayed_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_data_reg;

    a_read_not_at_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && state_reg == ST_IDLE) |-> (rd_addr != wp_reg))
        else $error("delay line read issued at the write pointer");

    a_lowpass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOWPASS) |=> $stable(lp_reg))
        else $error("lowpass state changed outside its update step");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WRITE))
        else $error("result word raised without a write-back");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("delay line fill flag dropped");

endmodule

### verif/mdcf_result_checker.sv
// mdcf_result_checker: watches the audio, result and config channels of the comb filter,
// predicts every out_sample word and compares it with the block's result stream
// depends on mdcf_pkg and the channel interfaces in mdcf_if
module mdcf_result_checker import mdcf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mdcf_in_if          audio,
    mdcf_out_if         result,
    mdcf_cfg_if         cfg,
    output int unsigned pending,
    output int unsigned errors
);

    localparam longint S24_LO   = -8388608;
    localparam longint S24_HI   = 8388607;
    localparam longint GAIN_LIM = 32440;

    line_sample_t      line_mem [LINE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr;
    longint            lp_acc;

    logic [16:0]        reg_base;
    logic signed [15:0] reg_fb;
    logic [14:0]        reg_damp;
    logic [17:0]        reg_rate;

    line_sample_t expected_out [$];
    line_sample_t want;
    int unsigned  err_count;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // one sample through the filter: returns the delayed word, updates line and lowpass
    function automatic line_sample_t filter_step(input in_sample_t x, input in_sample_t m);
        longint            base;
        longint            factor;
        longint            dyn_us;
        longint            rate;
        longint            tap;
        longint            off;
        longint            fbk;
        longint            damp;
        longint            delayed;
        longint            lp;
        longint            fb_term;
        logic [ADDR_W-1:0] rd;
        base    = clip(longint'(reg_base), 200, 80000);
        factor  = (longint'(1) << 30) + 19661 * longint'(m);
        dyn_us  = clip((base * factor) >>> 30, 200, 80000);
        rate    = (reg_rate == '0) ? 1 : longint'(reg_rate);
        tap     = clip((dyn_us * rate) / 1000000, 1, LINE_DEPTH - 1);
        off     = (6554 * longint'(m)) >>> 15;
        fbk     = clip(clip(longint'(reg_fb), -GAIN_LIM, GAIN_LIM) + off, -GAIN_LIM, GAIN_LIM);
        damp    = clip(clip(longint'(reg_damp), 0, GAIN_LIM) + off, 0, GAIN_LIM);
        rd      = wr_ptr - tap[ADDR_W-1:0];
        delayed = longint'(line_mem[rd]);
        lp      = clip(lp_acc + ((damp * (delayed - lp_acc)) >>> 15), S24_LO, S24_HI);
        lp_acc  = lp;
        fb_term = (lp * fbk) >>> 15;
        line_mem[wr_ptr] = line_sample_t'(clip(longint'(x) + fb_term, S24_LO, S24_HI));
        wr_ptr  = wr_ptr + 1'b1;
        return line_sample_t'(delayed);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_mem[i] = '0;
            end
            wr_ptr    = '0;
            lp_acc    = 0;
            reg_base  = BASE_DELAY_RESET;
            reg_fb    = '0;
            reg_damp  = '0;
            reg_rate  = SAMPLE_RATE_RESET;
            err_count = 0;
            expected_out.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_BASE_DELAY:  reg_base = cfg.data[16:0];
                    CFG_FEEDBACK:    reg_fb   = cfg.data[15:0];
                    CFG_DAMPING:     reg_damp = cfg.data[14:0];
                    CFG_SAMPLE_RATE: reg_rate = cfg.data[17:0];
                    default:         ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    err_count++;
                    $error("out_sample with no word pending: expected none, actual %0d",
                           result.out_sample);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (result.out_sample !== want)
                    begin
                        err_count++;
                        $error("out_sample mismatch: expected %0d, actual %0d",
                               want, result.out_sample);
                    end
                end
            end
            if (audio.valid && audio.ready)
            begin
                expected_out.push_back(filter_step(audio.in_sample, audio.mod_sample));
            end
            pending <= expected_out.size();
            errors  <= err_count;
        end
    end

endmodule

### verif/tb_modulated_damped_comb_filter.sv
// tb_modulated_damped_comb_filter: drives audio words and register settings into the comb
// filter with random idling on both sides; depends on mdcf_pkg, mdcf_if, the block itself
// and mdcf_result_checker, which predicts and compares every result word
module tb_modulated_damped_comb_filter;
    import mdcf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 150;
    localparam int TAIL_CYCLES  = 24;

    logic        clk;
    logic        rst_n;
    int unsigned pending;
    int unsigned errors;
    int unsigned words_sent;
    int unsigned settings_written;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int unsigned cycle_count;

    mdcf_in_if  audio_ch ();
    mdcf_out_if result_ch ();
    mdcf_cfg_if cfg_ch ();

    modulated_damped_comb_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .audio  (audio_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mdcf_result_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .audio   (audio_ch),
        .result  (result_ch),
        .cfg     (cfg_ch),
        .pending (pending),
        .errors  (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_settings(input mdcf_cfg_t s);
        write_reg(CFG_BASE_DELAY, CFG_DATA_W'(s.base_delay_us));
        write_reg(CFG_FEEDBACK, CFG_DATA_W'(s.feedback_gain));
        write_reg(CFG_DAMPING, CFG_DATA_W'(s.damping_gain));
        write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(s.sample_rate_hz));
        cfg_ch.valid <= 1'b0;
        settings_written++;
    endtask

    task automatic send_word(input in_sample_t x, input in_sample_t m);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            audio_ch.valid <= 1'b0;
            @(posedge clk);
        end
        audio_ch.valid      <= 1'b1;
        audio_ch.in_sample  <= x;
        audio_ch.mod_sample <= m;
        @(posedge clk);
        while (!audio_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic drain();
        audio_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    function automatic mdcf_cfg_t random_settings();
        mdcf_cfg_t   s;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            // short loops so feedback and damping act within one phase
            s.base_delay_us  = 17'($urandom_range(200, 3000));
            s.sample_rate_hz = 18'($urandom_range(8000, 48000));
        end
        else if (pick < 8)
        begin
            s.base_delay_us  = 17'($urandom_range(200, 80000));
            s.sample_rate_hz = 18'($urandom_range(1, 192000));
        end
        else
        begin
            s.base_delay_us  = 17'($urandom());
            s.sample_rate_hz = 18'($urandom());
        end
        case ($urandom_range(9))
            0:       s.feedback_gain = 16'sd32440;
            1:       s.feedback_gain = -16'sd32440;
            2:       s.feedback_gain = 16'($urandom());
            default: s.feedback_gain = 16'(int'($urandom_range(64880)) - 32440);
        endcase
        case ($urandom_range(9))
            0:       s.damping_gain = 15'd32440;
            1:       s.damping_gain = 15'd0;
            2:       s.damping_gain = 15'($urandom());
            default: s.damping_gain = 15'($urandom_range(32440));
        endcase
        return s;
    endfunction

    initial
    begin
        in_sample_t edge_vals [3];
        mdcf_cfg_t  s;
        in_sample_t x;
        in_sample_t m;
        edge_vals = '{-16'sd32768, 16'sd0, 16'sd32767};
        words_sent       = 0;
        settings_written = 0;
        tx_idle_pct      = 25;
        rx_idle_pct      = 51;
        rst_n               <= 1'b0;
        audio_ch.valid      <= 1'b0;
        audio_ch.in_sample  <= '0;
        audio_ch.mod_sample <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_BASE_DELAY;
        cfg_ch.data         <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes under the reset settings
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                send_word(edge_vals[i], edge_vals[j]);
            end
        end
        drain();

        // registers beyond their limits, zero rate gives the shortest tap
        s = '{base_delay_us: 17'd0, feedback_gain: 16'sh7FFF, damping_gain: 15'h7FFF,
              sample_rate_hz: 18'd0};
        write_settings(s);
        for (int i = 0; i < 4; i++)
        begin
            send_word(16'sd32767, edge_vals[2 * (i % 2)]);
        end
        drain();

        // longest delay, tap clamped to the top of the line
        s = '{base_delay_us: 17'h1FFFF, feedback_gain: -16'sd32768, damping_gain: 15'd0,
              sample_rate_hz: 18'h3FFFF};
        write_settings(s);
        for (int i = 0; i < 4; i++)
        begin
            send_word(-16'sd32768, edge_vals[i % 3]);
        end
        drain();

        // gains at their legal edges, shortest legal delay
        s = '{base_delay_us: 17'd200, feedback_gain: -16'sd32440, damping_gain: 15'd32440,
              sample_rate_hz: 18'd192000};
        write_settings(s);
        for (int i = 0; i < 4; i++)
        begin
            send_word(edge_vals[2 * (i % 2)], edge_vals[(i + 1) % 3]);
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < PHASES / 3)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 51;
            end
            else if (p < 2 * PHASES / 3)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_settings(random_settings());
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                case ($urandom_range(9))
                    0:       x = 16'sd32767;
                    1:       x = -16'sd32768;
                    default: x = 16'($urandom());
                endcase
                case ($urandom_range(9))
                    0:       m = 16'sd0;
                    1:       m = edge_vals[2 * $urandom_range(1)];
                    default: m = 16'($urandom());
                endcase
                send_word(x, m);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d audio words under %0d register settings with idling on both sides",
                 words_sent, settings_written);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### modulated_damped_comb_filter.f
hw/rtl/mdcf_pkg.sv
hw/rtl/mdcf_if.sv
hw/rtl/mdcf_ram.sv
hw/rtl/mdcf_front.sv
hw/rtl/mdcf_queue.sv
hw/rtl/mdcf_back.sv
hw/rtl/modulated_damped_comb_filter.sv
verif/mdcf_result_checker.sv
verif/tb_modulated_damped_comb_filter.sv
